// File: rtl/assert_macros.svh
// Assertion macros shared by the set table RTL.
// No dependencies; defining ASSERT_OFF compiles the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: rtl/bust_pkg.sv
// Package for the bounded unique set table: operation codes, sequencer
// states, result beat layout and register constants. No dependencies.
package bust_pkg;

   localparam int OP_W        = 2;
   localparam int FIELD_W     = 32;
   localparam int POS_W       = 8;
   localparam int COUNT_OUT_W = 9;
   localparam int CAP_W       = 9;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;
   localparam logic [0:0]       REG_CAPACITY   = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_ERASE    = 2'd1,
      OP_CONTAINS = 2'd2,
      OP_GET      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_GET,
      ST_GET_DATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [COUNT_OUT_W-1:0] item_count;
      logic [FIELD_W-1:0]     read_item;
      logic                   success;
   } rsp_type;

endpackage

// File: rtl/bust_core.sv
// Set table core: entry RAM, one shared compare unit and the sequencer that
// scans, shifts, appends and reads entries. Depends on bust_pkg, assert_macros.svh.
`include "assert_macros.svh"
module bust_core #(
   parameter int DEPTH      = 256,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  bust_pkg::op_type                     op,
   input  logic [bust_pkg::FIELD_W-1:0]         item_value,
   input  logic [bust_pkg::POS_W-1:0]           position,
   input  logic [bust_pkg::CAP_W-1:0]           capacity,
   output logic                                 ready,
   output logic                                 res_valid,
   input  logic                                 res_take,
   output bust_pkg::rsp_type                    res
);
   import bust_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [ITEM_WIDTH-1:0] key_ff, key_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  success_ff, success_in;
   logic [FIELD_W-1:0]    rdata_ff, rdata_in;

   logic [ITEM_WIDTH-1:0] mem [DEPTH];
   logic [ITEM_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]         rd_addr, wr_addr, pos_addr;
   logic                  wr_en;
   logic [ITEM_WIDTH-1:0] wr_data;

   logic [63:0]           value_wide, rd_wide;
   logic [ITEM_WIDTH-1:0] item_conv;
   logic [CW-1:0]         limit, shift_dst;
   logic [31:0]           count_wide;
   logic                  issue, hit, scan_end, room, pos_ok;

   assign value_wide = {32'd0, item_value};
   assign item_conv  = value_wide[ITEM_WIDTH-1:0];
   assign rd_wide    = 64'(rd_data_ff);
   assign count_wide = 32'(count_ff);
   assign pos_addr   = AW'(pos_ff);
   assign shift_dst  = cmp_idx_ff - 1'b1;

   assign limit    = (32'(capacity) < 32'(DEPTH)) ? CW'(capacity) : CW'(DEPTH);
   assign issue    = idx_ff < count_ff;
   // shared compare unit
   assign hit      = cmp_vld_ff && (rd_data_ff == key_ff);
   assign scan_end = !issue && !cmp_vld_ff;
   assign room     = count_ff < limit;
   assign pos_ok   = 32'(pos_ff) < count_wide;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      success_ff <= success_in;
      rdata_ff   <= rdata_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (op == OP_GET) ? ST_GET : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = (op_ff == OP_ERASE) ? ST_SHIFT : ST_DONE;
            end else if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_GET:      state_in = ST_GET_DATA;
         ST_GET_DATA: state_in = ST_DONE;
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      op_in      = op_ff;
      key_in     = key_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = 1'b0;
      count_in   = count_ff;
      success_in = success_ff;
      rdata_in   = rdata_ff;
      rd_addr    = idx_ff[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = op;
               key_in     = item_conv;
               pos_in     = position;
               idx_in     = '0;
               success_in = 1'b0;
               rdata_in   = '0;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = issue;
            cmp_idx_in = idx_ff;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (hit) begin
               cmp_vld_in = 1'b0;
               case (op_ff)
                  OP_CONTAINS: success_in = 1'b1;
                  OP_ERASE:    idx_in = cmp_idx_ff + 1'b1;
                  default:     success_in = 1'b0;
               endcase
            end else if (scan_end && op_ff == OP_INSERT && room) begin
               wr_en      = 1'b1;
               wr_addr    = count_ff[AW-1:0];
               wr_data    = key_ff;
               count_in   = count_ff + 1'b1;
               success_in = 1'b1;
            end
         end
         ST_SHIFT: begin
            cmp_vld_in = issue;
            cmp_idx_in = idx_ff;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_dst[AW-1:0];
               wr_data = rd_data_ff;
            end
            if (scan_end) begin
               count_in   = count_ff - 1'b1;
               success_in = 1'b1;
            end
         end
         ST_GET: begin
            rd_addr = pos_addr;
         end
         ST_GET_DATA: begin
            if (pos_ok) begin
               success_in = 1'b1;
               rdata_in   = rd_wide[FIELD_W-1:0];
            end
         end
         ST_DONE: begin
            cmp_vld_in = 1'b0;
         end
         default: begin
            cmp_vld_in = 1'b0;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      ready          = (state_ff == ST_IDLE);
      res_valid      = (state_ff == ST_DONE);
      res.success    = success_ff;
      res.read_item  = rdata_ff;
      res.item_count = count_wide[COUNT_OUT_W-1:0];
   end

   `ASSERT_CLK(a_count_bound, clock, reset, count_wide <= 32'(DEPTH), "count above depth")
   `ASSERT_CLK(a_count_step, clock, reset, count_ff == $past(count_ff) || count_wide == 32'($past(count_ff)) + 32'd1 || count_wide + 32'd1 == 32'($past(count_ff)), "count moved by more than one")
   `ASSERT_CLK(a_count_hold, clock, reset, ($past(state_ff) != ST_SCAN && $past(state_ff) != ST_SHIFT) |-> $stable(count_ff), "count changed outside scan or shift")
   `ASSERT_NEVER(a_wr_idle, clock, reset, wr_en && (state_ff == ST_IDLE || state_ff == ST_DONE), "RAM write while not working")
   `ASSERT_CLK(a_start_busy, clock, reset, (start && ready) |=> (state_ff != ST_IDLE), "accepted beat left sequencer idle")

endmodule

// File: rtl/bounded_unique_set_table_top.sv
// Insert and contains scan the stored entries; erase also shifts the later
// entries down, and get reads the entry at the given position.
// One item at a time: req_tready stays low until the result leaves the core,
// and an rsp_tready stall can hold the result in the core.
// Reset (synchronous, active high) empties the set and sets capacity to 256.
module bounded_unique_set_table_top #(
   parameter int DEPTH      = 256,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] operation, [33:2] item_value, [41:34] position, [47:42] zero
   input  logic [bust_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] success, [32:1] read_item, [41:33] item_count, [47:42] zero
   output logic [bust_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bust_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import bust_pkg::*;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   rsp_type          core_res;
   logic             core_ready, core_res_valid, core_res_take;
   logic             start, csr_wr;
   op_type           req_op;

   assign req_op = op_type'(req_tdata[1:0]);
   assign start  = req_tvalid && core_ready;

   bust_core #(
      .DEPTH      (DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .op         (req_op),
      .item_value (req_tdata[33:2]),
      .position   (req_tdata[41:34]),
      .capacity   (capacity_ff),
      .ready      (core_ready),
      .res_valid  (core_res_valid),
      .res_take   (core_res_take),
      .res        (core_res)
   );

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr && csr_paddr[2] == REG_CAPACITY) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      csr_pready = 1'b1;
      csr_prdata = '0;
      if (csr_paddr[2] == REG_CAPACITY) begin
         csr_prdata = 32'(capacity_ff);
      end
   end

   // output register: the core hands over a result when the register is free or is being emptied
   assign core_res_take = core_res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign req_tready = core_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.item_count, rsp_ff.read_item, rsp_ff.success};

endmodule
